>>> rtl/isim_pkg.sv
`default_nettype none

package isim_pkg;

    localparam int unsigned DEF_MAX_SUBS   = 1024;
    localparam int unsigned DEF_NUM_ATTRS  = 32;
    localparam int unsigned DEF_VALUE_BITS = 20;

    // Fixed field widths of the stream words
    localparam int unsigned SUB_ID_W   = 10;
    localparam int unsigned ATTR_IN_W  = 5;
    localparam int unsigned VALUE_IN_W = 20;
    localparam int unsigned COUNT_W    = 11;

    // s_tdata field positions, lowest first
    localparam int unsigned SUB_LSB  = 0;
    localparam int unsigned ATTR_LSB = SUB_LSB + SUB_ID_W;
    localparam int unsigned LOW_LSB  = ATTR_LSB + ATTR_IN_W;
    localparam int unsigned HIGH_LSB = LOW_LSB + VALUE_IN_W;
    localparam int unsigned EVT_LSB  = HIGH_LSB + VALUE_IN_W;
    localparam int unsigned S_FIELDS_W = EVT_LSB + VALUE_IN_W;
    localparam int unsigned S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W  = ((COUNT_W + 7) / 8) * 8;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_PAIR   = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INS_RD,
        ST_INS_WR,
        ST_SCAN,
        ST_COUNT,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

>>> rtl/interval_subscription_matcher.sv
`default_nettype none

// Interval subscription matcher. A word with tuser = 0 stores the bound pair
// [low, high] for one subscription slot and attribute; a word with tuser = 1 is
// one attribute-value pair of an event, and the pair with tlast high ends the
// event and yields one count of slots not excluded (slots with no constraints
// count). Constraints sit in a single-port-read RAM of MAX_SUBS*NUM_ATTRS
// entries; a second RAM holds one row per slot with its constrained-attribute
// mask and excluded flag. An insert is accepted, then reads and writes the
// slot row. A pair with a valid attribute is accepted, then the constraint
// RAM read port walks every slot once and the slot pipeline drains. The last
// pair adds a count pass over the slot RAM, which also clears the excluded
// flags, and a load of the result, which is held back while an earlier count
// still waits on m_tready. After reset a clearing pass empties the slot RAM
// before the first word is taken. The result sits in an output register, so
// the next word is taken while the count waits on m_tready.
module interval_subscription_matcher
#(
    parameter int MAX_SUBS   = isim_pkg::DEF_MAX_SUBS,
    parameter int NUM_ATTRS  = isim_pkg::DEF_NUM_ATTRS,
    parameter int VALUE_BITS = isim_pkg::DEF_VALUE_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // sub_id[9:0], attribute[14:10], low_value[34:15], high_value[54:35],
    // event_value[74:55], zero fill above
    input  wire logic [isim_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  wire logic                          s_tuser,
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // match_count[10:0], zero fill above
    output logic      [isim_pkg::M_TDATA_W-1:0] m_tdata
);

    import isim_pkg::*;

    localparam int SUB_W   = (MAX_SUBS > 1) ? $clog2(MAX_SUBS) : 1;
    localparam int ATTR_W  = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;
    localparam int DEPTH   = MAX_SUBS * NUM_ATTRS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W   = NUM_ATTRS + 1;
    localparam int CSTR_W  = 2 * VALUE_BITS;
    localparam logic [SUB_W:0] LAST_ISS = (SUB_W + 1)'(MAX_SUBS);

    state_t state_reg, state_next;

    logic [SUB_W:0]          iss_reg, iss_next;
    logic                    pipe_vld_reg, pipe_vld_next;
    logic [SUB_W-1:0]        pipe_idx_reg, pipe_idx_next;
    logic [ADDR_W-1:0]       scan_addr_reg, scan_addr_next;
    logic [NUM_ATTRS-1:0]    seen_reg, seen_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic                    out_vld_reg, out_vld_next;
    logic [COUNT_W-1:0]      out_cnt_reg, out_cnt_next;

    logic [SUB_W-1:0]        sub_reg, sub_next;
    logic [ATTR_W-1:0]       att_reg, att_next;
    logic [VALUE_BITS-1:0]   lo_reg, lo_next;
    logic [VALUE_BITS-1:0]   hi_reg, hi_next;
    logic [VALUE_BITS-1:0]   val_reg, val_next;
    logic                    last_reg, last_next;

    logic                    s_acc;
    logic                    sub_ok;
    logic                    att_ok;
    logic                    is_insert;
    logic                    issuing;
    logic                    pass_done;
    logic                    emit_ok;

    logic                    slot_wr_en;
    logic [SUB_W-1:0]        slot_wr_addr;
    logic [ROW_W-1:0]        slot_wr_data;
    logic [SUB_W-1:0]        slot_rd_addr;
    logic [ROW_W-1:0]        slot_rd_data;

    logic                    cstr_wr_en;
    logic [ADDR_W-1:0]       cstr_wr_addr;
    logic [CSTR_W-1:0]       cstr_wr_data;
    logic [CSTR_W-1:0]       cstr_rd_data;

    logic [NUM_ATTRS-1:0]    row_mask;
    logic                    row_excl;
    logic [VALUE_BITS-1:0]   rd_lo;
    logic [VALUE_BITS-1:0]   rd_hi;
    logic                    miss;

    assign s_acc     = s_tvalid && s_tready;
    assign sub_ok    = 32'(s_tdata[SUB_LSB +: SUB_ID_W]) < 32'(MAX_SUBS);
    assign att_ok    = 32'(s_tdata[ATTR_LSB +: ATTR_IN_W]) < 32'(NUM_ATTRS);
    assign is_insert = kind_t'(s_tuser) == KIND_INSERT;
    assign issuing   = iss_reg != LAST_ISS;
    assign pass_done = !issuing && !pipe_vld_reg;
    assign emit_ok   = !out_vld_reg || m_tready;

    assign row_mask = slot_rd_data[NUM_ATTRS-1:0];
    assign row_excl = slot_rd_data[NUM_ATTRS];
    assign rd_lo    = cstr_rd_data[VALUE_BITS-1:0];
    assign rd_hi    = cstr_rd_data[CSTR_W-1:VALUE_BITS];
    assign miss     = row_mask[att_reg] && ((rd_lo > val_reg) || (rd_hi < val_reg));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (!issuing) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_acc) begin
                    if (is_insert) begin
                        if (sub_ok && att_ok) state_next = ST_INS_RD;
                    end else if (att_ok) begin
                        state_next = ST_SCAN;
                    end else if (s_tlast) begin
                        state_next = ST_COUNT;
                    end
                end
            end
            ST_INS_RD: state_next = ST_INS_WR;
            ST_INS_WR: state_next = ST_IDLE;
            ST_SCAN: begin
                if (pass_done) state_next = last_reg ? ST_COUNT : ST_IDLE;
            end
            ST_COUNT: begin
                if (pass_done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_ok) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready       = 1'b0;
        iss_next       = '0;
        pipe_vld_next  = 1'b0;
        pipe_idx_next  = iss_reg[SUB_W-1:0];
        scan_addr_next = scan_addr_reg;
        seen_next      = seen_reg;
        count_next     = count_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        out_cnt_next   = out_cnt_reg;
        sub_next       = sub_reg;
        att_next       = att_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        val_next       = val_reg;
        last_next      = last_reg;
        slot_wr_en     = 1'b0;
        slot_wr_addr   = pipe_idx_reg;
        slot_wr_data   = '0;
        slot_rd_addr   = iss_reg[SUB_W-1:0];
        cstr_wr_en     = 1'b0;
        cstr_wr_addr   = ADDR_W'(32'(sub_reg) * 32'(NUM_ATTRS) + 32'(att_reg));
        cstr_wr_data   = {hi_reg, lo_reg};

        unique case (state_reg)
            ST_CLEAR: begin
                if (issuing) begin
                    iss_next     = iss_reg + 1'b1;
                    slot_wr_en   = 1'b1;
                    slot_wr_addr = iss_reg[SUB_W-1:0];
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_acc) begin
                    sub_next  = SUB_W'(s_tdata[SUB_LSB +: SUB_ID_W]);
                    att_next  = ATTR_W'(s_tdata[ATTR_LSB +: ATTR_IN_W]);
                    lo_next   = VALUE_BITS'(s_tdata[LOW_LSB +: VALUE_IN_W]);
                    hi_next   = VALUE_BITS'(s_tdata[HIGH_LSB +: VALUE_IN_W]);
                    val_next  = VALUE_BITS'(s_tdata[EVT_LSB +: VALUE_IN_W]);
                    last_next = s_tlast;
                    scan_addr_next = ADDR_W'(s_tdata[ATTR_LSB +: ATTR_IN_W]);
                    if (!is_insert && att_ok) begin
                        seen_next[ATTR_W'(s_tdata[ATTR_LSB +: ATTR_IN_W])] = 1'b1;
                    end
                end
            end
            ST_INS_RD: begin
                slot_rd_addr = sub_reg;
            end
            ST_INS_WR: begin
                // slot row read last cycle: mark the attribute as constrained
                slot_wr_en   = 1'b1;
                slot_wr_addr = sub_reg;
                slot_wr_data = slot_rd_data;
                slot_wr_data[att_reg] = 1'b1;
                cstr_wr_en   = 1'b1;
            end
            ST_SCAN: begin
                if (issuing) begin
                    iss_next       = iss_reg + 1'b1;
                    pipe_vld_next  = 1'b1;
                    scan_addr_next = scan_addr_reg + ADDR_W'(NUM_ATTRS);
                end else if (pipe_vld_reg) begin
                    iss_next = iss_reg;
                end
                if (pipe_vld_reg && miss) begin
                    slot_wr_en   = 1'b1;
                    slot_wr_data = {1'b1, row_mask};
                end
            end
            ST_COUNT: begin
                if (issuing) begin
                    iss_next      = iss_reg + 1'b1;
                    pipe_vld_next = 1'b1;
                end else if (pipe_vld_reg) begin
                    iss_next = iss_reg;
                end
                // drop the excluded flag as each row is counted
                if (pipe_vld_reg) begin
                    slot_wr_en   = 1'b1;
                    slot_wr_data = {1'b0, row_mask};
                    if (!row_excl && !(|(row_mask & ~seen_reg))) begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (emit_ok) begin
                    out_vld_next = 1'b1;
                    out_cnt_next = count_reg;
                    count_next   = '0;
                    seen_next    = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            iss_reg      <= '0;
            pipe_vld_reg <= 1'b0;
            seen_reg     <= '0;
            count_reg    <= '0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            iss_reg      <= iss_next;
            pipe_vld_reg <= pipe_vld_next;
            seen_reg     <= seen_next;
            count_reg    <= count_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        pipe_idx_reg  <= pipe_idx_next;
        scan_addr_reg <= scan_addr_next;
        out_cnt_reg   <= out_cnt_next;
        sub_reg       <= sub_next;
        att_reg       <= att_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        val_reg       <= val_next;
        last_reg      <= last_next;
    end

    isim_ram #(
        .DEPTH (MAX_SUBS),
        .WIDTH (ROW_W)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data)
    );

    isim_ram #(
        .DEPTH (DEPTH),
        .WIDTH (CSTR_W)
    ) u_cstr_ram (
        .aclk    (aclk),
        .wr_en   (cstr_wr_en),
        .wr_addr (cstr_wr_addr),
        .wr_data (cstr_wr_data),
        .rd_addr (scan_addr_reg),
        .rd_data (cstr_rd_data)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = M_TDATA_W'(out_cnt_reg);

    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !pipe_vld_reg)
        else $error("slot pipeline busy while taking words");

    a_rise_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_vld_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside the emit step");

    a_seen_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && emit_ok) |=> seen_reg == '0 && count_reg == '0)
        else $error("event state not cleared after result");

endmodule

`default_nettype wire

>>> rtl/isim_ram.sv
`default_nettype none

module isim_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 33,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> sim/interval_subscription_matcher_tb.sv
`default_nettype none

module interval_subscription_matcher_tb;
    import isim_pkg::*;

    localparam int NSLOTS      = DEF_MAX_SUBS;
    localparam int NATTRS      = DEF_NUM_ATTRS;
    localparam int PASS_CYCLES = NSLOTS + 2;
    localparam int QUIET_LIMIT = 40000;
    localparam int HOLD_STRETCH = 8000;

    typedef struct {
        kind_t                 kind;
        bit [SUB_ID_W-1:0]     sub_id;
        bit [ATTR_IN_W-1:0]    attribute;
        bit [VALUE_IN_W-1:0]   low_value;
        bit [VALUE_IN_W-1:0]   high_value;
        bit [VALUE_IN_W-1:0]   event_value;
        bit                    last;
    } matcher_word_t;

    // Tracks the constraint store and the running event, and holds the counts
    // that pending events will produce.
    class match_scoreboard;
        bit [VALUE_IN_W-1:0] bound_lo [NSLOTS*NATTRS];
        bit [VALUE_IN_W-1:0] bound_hi [NSLOTS*NATTRS];
        bit                  bound_set [NSLOTS*NATTRS];
        bit [NATTRS-1:0]     slot_attrs [NSLOTS];
        bit                  slot_out [NSLOTS];
        bit [NATTRS-1:0]     attrs_seen;
        bit [COUNT_W-1:0]    expected_counts [$];
        int errors;
        int counts_checked;
        int inserts;
        int pairs;
        int events;

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function void note_word(matcher_word_t w);
            int ix;
            int s;
            int unsigned tally;
            if (w.kind == KIND_INSERT) begin
                inserts++;
                ix = w.sub_id * NATTRS + w.attribute;
                bound_lo[ix]  = w.low_value;
                bound_hi[ix]  = w.high_value;
                bound_set[ix] = 1'b1;
                slot_attrs[w.sub_id][w.attribute] = 1'b1;
                return;
            end
            pairs++;
            attrs_seen[w.attribute] = 1'b1;
            for (s = 0; s < NSLOTS; s++) begin
                ix = s * NATTRS + w.attribute;
                if (bound_set[ix] &&
                    (bound_lo[ix] > w.event_value || bound_hi[ix] < w.event_value))
                    slot_out[s] = 1'b1;
            end
            if (!w.last)
                return;
            // a slot also drops out when it constrains an attribute left out
            events++;
            tally = 0;
            for (s = 0; s < NSLOTS; s++) begin
                if (!slot_out[s] && (slot_attrs[s] & ~attrs_seen) == '0)
                    tally++;
                slot_out[s] = 1'b0;
            end
            attrs_seen = '0;
            expected_counts.insert(expected_counts.size(), tally[COUNT_W-1:0]);
        endfunction

        task check_count(bit [COUNT_W-1:0] got);
            bit [COUNT_W-1:0] want;
            if (expected_counts.size() == 0) begin
                report($sformatf("count %0d arrived with no event pending", got));
                return;
            end
            want = expected_counts.pop_front();
            counts_checked++;
            if (got !== want)
                report($sformatf("event %0d: match_count %0d, expected %0d",
                                 counts_checked, got, want));
        endtask
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    match_scoreboard sb = new();
    int sender_idle_pct  = 0;
    int receiver_stall_pct = 0;
    int hold_cycles      = 0;
    int quiet_cycles     = 0;
    int words_sent       = 0;

    interval_subscription_matcher DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Receiver: hold off for the requested stretch, otherwise stall at random.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Check counts and watch for a stuck handshake.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_count(m_tdata[COUNT_W-1:0]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
                $display("interval_subscription_matcher regression: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic matcher_word_t random_word();
        matcher_word_t w;
        w.kind        = kind_t'($urandom_range(0, 1));
        w.sub_id      = SUB_ID_W'($urandom);
        w.attribute   = ATTR_IN_W'($urandom);
        w.low_value   = VALUE_IN_W'($urandom);
        w.high_value  = VALUE_IN_W'($urandom);
        w.event_value = VALUE_IN_W'($urandom);
        w.last        = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // Mostly a narrow range so bounds and event values overlap often.
    function automatic bit [VALUE_IN_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2, 3:    return VALUE_IN_W'($urandom);
            default: return VALUE_IN_W'($urandom_range(0, 511));
        endcase
    endfunction

    task automatic send_word(matcher_word_t w);
        logic [S_TDATA_W-1:0] data;
        data = '0;
        data[SUB_LSB  +: SUB_ID_W]   = w.sub_id;
        data[ATTR_LSB +: ATTR_IN_W]  = w.attribute;
        data[LOW_LSB  +: VALUE_IN_W] = w.low_value;
        data[HIGH_LSB +: VALUE_IN_W] = w.high_value;
        data[EVT_LSB  +: VALUE_IN_W] = w.event_value;
        @(negedge aclk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= w.kind;
        s_tlast  <= w.last;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(w);
        words_sent++;
    endtask

    task automatic send_insert(int sub, int attr, int lo, int hi, bit last);
        matcher_word_t w;
        w            = random_word();
        w.kind       = KIND_INSERT;
        w.sub_id     = SUB_ID_W'(sub);
        w.attribute  = ATTR_IN_W'(attr);
        w.low_value  = VALUE_IN_W'(lo);
        w.high_value = VALUE_IN_W'(hi);
        w.last       = last;
        send_word(w);
    endtask

    task automatic send_pair(int attr, int value, bit last);
        matcher_word_t w;
        w             = random_word();
        w.kind        = KIND_PAIR;
        w.attribute   = ATTR_IN_W'(attr);
        w.event_value = VALUE_IN_W'(value);
        w.last        = last;
        send_word(w);
    endtask

    task automatic wait_for_counts();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_counts.size() != 0)
            @(posedge aclk);
    endtask

    task automatic random_insert();
        bit [VALUE_IN_W-1:0] lo;
        bit [VALUE_IN_W-1:0] hi;
        bit [VALUE_IN_W-1:0] tmp;
        int sub;
        int attr;
        lo = pick_value();
        hi = pick_value();
        // keep most bounds ordered, leave some inverted
        if (lo > hi && $urandom_range(0, 6) != 0) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        sub  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 63) : $urandom_range(0, NSLOTS - 1);
        attr = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(0, NATTRS - 1);
        send_insert(sub, attr, int'(lo), int'(hi), 1'($urandom_range(0, 1)));
    endtask

    task automatic random_event();
        int npairs;
        bit sweep;
        int attr;
        sweep  = ($urandom_range(0, 9) < 3);
        npairs = sweep ? 4 :
                 ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
        for (int p = 0; p < npairs; p++) begin
            if ($urandom_range(0, 9) == 0)
                random_insert();
            if (sweep)
                attr = p;
            else
                attr = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
                                                    : $urandom_range(0, NATTRS - 1);
            send_pair(attr, int'(pick_value()), p == npairs - 1);
        end
    endtask

    task automatic run_phase(int n_words, int idle_pct, int stall_pct, bit long_hold);
        int stop_at;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        if (long_hold) begin
            @(posedge aclk);
            hold_cycles = HOLD_STRETCH;
        end
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 99) < 45)
                random_insert();
            else
                random_event();
        end
        wait_for_counts();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty store: every slot counts
        send_pair(0, 0, 1'b1);
        // extremes, an overwrite and inverted bounds
        send_insert(0, 0, 0, 'hFFFFF, 1'b0);
        send_insert(NSLOTS - 1, NATTRS - 1, 'hFFFFF, 'hFFFFF, 1'b0);
        send_insert(5, 3, 100, 50, 1'b0);
        send_insert(5, 3, 10, 200, 1'b0);
        send_insert(6, 3, 300, 200, 1'b0);
        send_pair(3, 150, 1'b0);
        send_pair(0, 'hFFFFF, 1'b0);
        send_pair(NATTRS - 1, 'hFFFFF, 1'b1);
        // tlast on an insert gives nothing
        send_insert(7, 1, 0, 0, 1'b1);
        // attributes left out exclude their slots
        send_pair(3, 0, 1'b1);
        // repeated attribute in one event
        send_pair(1, 0, 1'b0);
        send_pair(1, 1, 1'b0);
        send_pair(3, 10, 1'b0);
        send_pair(0, 0, 1'b0);
        send_pair(NATTRS - 1, 'hFFFFF, 1'b1);
        // store changes mid-event
        send_pair(0, 5, 1'b0);
        send_insert(8, 2, 0, 5, 1'b0);
        send_pair(2, 5, 1'b0);
        send_pair(2, 6, 1'b1);
        wait_for_counts();

        run_phase(140, 0, 0, 1'b0);
        run_phase(140, 65, 0, 1'b0);
        run_phase(140, 0, 65, 1'b1);
        run_phase(140, 16, 16, 1'b0);

        repeat (2 * PASS_CYCLES + 16) @(posedge aclk);
        $display("covered %0d constraint writes and %0d pairs in %0d events, %0d counts checked",
                 sb.inserts, sb.pairs, sb.events, sb.counts_checked);
        $display("idling: none, sender 65%%, receiver 65%% with a long hold-off, both 16%%");
        if (sb.errors == 0 && sb.expected_counts.size() == 0)
            $display("interval_subscription_matcher regression: pass");
        else
            $display("interval_subscription_matcher regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
